// ----- hw/rtl/psrch_pkg.sv -----
// Package with types, constants and sizes shared by the shift search block.
`default_nettype none
package psrch_pkg;

  localparam int MAX_LENGTH = 1024;
  localparam int ADDR_W     = $clog2(MAX_LENGTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int SAMPLE_W   = 16;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int SUM_W      = 48;
  localparam int COST_W     = 47;
  localparam int SHIFT_W    = 10;
  localparam int RANGE_W    = CNT_W - 2;
  localparam int IDX_W      = CNT_W + 1;

  localparam logic [SUM_W-1:0] COST_MAX = {1'b0, {COST_W{1'b1}}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
  } psrch_point_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] first_x;
    logic signed [SAMPLE_W-1:0] first_y;
    logic                       first_valid;
    logic signed [SAMPLE_W-1:0] second_x;
    logic signed [SAMPLE_W-1:0] second_y;
    logic                       second_valid;
    logic                       last;
  } psrch_in_t;

  typedef struct packed {
    logic signed [SHIFT_W-1:0] best_shift;
    logic [COST_W-1:0]         best_cost;
  } psrch_out_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_SETUP,
    ST_RUN,
    ST_DRAIN,
    ST_COMPARE,
    ST_DONE
  } psrch_state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/psrch_cross.sv -----
// Shared cross product unit: multiply, absolute difference and saturating accumulate.
`default_nettype none
module psrch_cross import psrch_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clear,
  input  logic               term_v,
  input  psrch_point_t       pa,
  input  psrch_point_t       pb,
  output logic [SUM_W-1:0]   sum,
  output logic               busy
);

  logic signed [PROD_W-1:0] p1_r, p2_r;
  logic                     p_v_r;
  logic [PROD_W-1:0]        mag_r;
  logic                     m_v_r;
  logic [SUM_W-1:0]         sum_r;

  logic signed [PROD_W-1:0] p1, p2;
  logic signed [PROD_W:0]   diff;
  logic [PROD_W-1:0]        mag;
  logic [SUM_W-1:0]         sum_nxt;

  always_comb begin
    p1 = pa.x * pb.y;
    p2 = pb.x * pa.y;
    diff = $signed({p1_r[PROD_W-1], p1_r}) - $signed({p2_r[PROD_W-1], p2_r});
    // The magnitude never exceeds 2^31, so it always fits the product width.
    mag = diff[PROD_W] ? PROD_W'(-diff) : diff[PROD_W-1:0];
    sum_nxt = sum_r + SUM_W'(mag_r);
    if (sum_nxt > COST_MAX) begin
      sum_nxt = COST_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      m_v_r <= 1'b0;
      sum_r <= '0;
    end else begin
      p_v_r <= term_v;
      m_v_r <= p_v_r;
      if (clear) begin
        sum_r <= '0;
      end else if (m_v_r) begin
        sum_r <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_r  <= p1;
    p2_r  <= p2;
    mag_r <= mag;
  end

  assign sum  = sum_r;
  assign busy = term_v | p_v_r | m_v_r;

endmodule
`default_nettype wire

// ----- hw/rtl/projection_shift_search.sv -----
// Top level: point stores, search sequencer and result register of the shift search.
// Loading takes one word per cycle; in_ready stays high while words are loaded.
// After the last word the sequencer steps through start, then setup, run, drain and compare for each
// of the 2R+1 shifts, with the shared cross product unit taking one term a cycle.
// The result is then held on out until taken, and the block is not ready meanwhile.
// Synchronous reset clears the counts, sequencer and result; the point stores are not cleared.
`default_nettype none
module projection_shift_search import psrch_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  psrch_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output psrch_out_t out_data
);

  psrch_state_t state_r, state_nxt;

  logic [PROD_W-1:0] ref_mem [MAX_LENGTH];
  logic [PROD_W-1:0] cmp_mem [MAX_LENGTH];

  logic [CNT_W-1:0]          ref_cnt_r, cmp_cnt_r;
  logic [RANGE_W-1:0]        range_r;
  logic signed [SHIFT_W-1:0] s_r;
  logic signed [IDX_W-1:0]   i_r, iend_r;
  logic                      rd_v_r;
  psrch_point_t              a_q, b_q;
  logic [SUM_W-1:0]          least_sum_r;
  logic signed [SHIFT_W-1:0] least_shift_r;

  logic                      accept, ref_we, cmp_we, issue, clear, busy;
  logic [RANGE_W-1:0]        r1, r2, range;
  logic signed [IDX_W-1:0]   s_ext, ist, iend, rem2, j;
  logic [SUM_W-1:0]          sum;

  assign accept = in_valid & in_ready;
  assign ref_we = accept & in_data.first_valid & (ref_cnt_r < CNT_W'(MAX_LENGTH));
  assign cmp_we = accept & in_data.second_valid & (cmp_cnt_r < CNT_W'(MAX_LENGTH));

  assign r1    = ref_cnt_r[CNT_W-1:2];
  assign r2    = cmp_cnt_r[CNT_W-1:2];
  assign range = (r1 > r2) ? r1 : r2;

  // Overlap of the two vectors at shift s: i from max(0,-s) up to min(n1, n2-s).
  assign s_ext = IDX_W'(s_r);
  assign ist   = s_r[SHIFT_W-1] ? -s_ext : '0;
  assign rem2  = $signed({1'b0, cmp_cnt_r}) - s_ext;
  assign iend  = (rem2 < $signed({1'b0, ref_cnt_r})) ? rem2 : $signed({1'b0, ref_cnt_r});
  assign j     = i_r + s_ext;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    issue     = 1'b0;
    clear     = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid && in_data.last) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        clear     = 1'b1;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (i_r < iend_r) begin
          issue = 1'b1;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!busy) begin
          state_nxt = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        if (s_r == $signed({1'b0, range_r})) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SETUP;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[ref_cnt_r[ADDR_W-1:0]] <= {in_data.first_x, in_data.first_y};
    end
    if (cmp_we) begin
      cmp_mem[cmp_cnt_r[ADDR_W-1:0]] <= {in_data.second_x, in_data.second_y};
    end
    if (issue) begin
      a_q <= ref_mem[i_r[ADDR_W-1:0]];
      b_q <= cmp_mem[j[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_cnt_r     <= '0;
      cmp_cnt_r     <= '0;
      rd_v_r        <= 1'b0;
      least_sum_r   <= '0;
      least_shift_r <= '0;
    end else begin
      rd_v_r <= issue;
      if (out_valid && out_ready) begin
        ref_cnt_r <= '0;
        cmp_cnt_r <= '0;
      end else begin
        if (ref_we) begin
          ref_cnt_r <= ref_cnt_r + CNT_W'(1);
        end
        if (cmp_we) begin
          cmp_cnt_r <= cmp_cnt_r + CNT_W'(1);
        end
      end
      // The first shift always seeds the minimum; later ones must be strictly less.
      if (state_r == ST_COMPARE) begin
        if (s_r == -$signed({1'b0, range_r}) || sum < least_sum_r) begin
          least_sum_r   <= sum;
          least_shift_r <= s_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_START) begin
      range_r <= range;
      s_r     <= -$signed({1'b0, range});
    end else if (state_r == ST_COMPARE) begin
      s_r <= s_r + SHIFT_W'(1);
    end
    if (state_r == ST_SETUP) begin
      i_r    <= ist;
      iend_r <= iend;
    end else if (issue) begin
      i_r <= i_r + IDX_W'(1);
    end
  end

  psrch_cross u_cross (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (clear),
    .term_v (rd_v_r),
    .pa     (a_q),
    .pb     (b_q),
    .sum    (sum),
    .busy   (busy)
  );

  assign out_data.best_shift = least_shift_r;
  assign out_data.best_cost  = least_sum_r[COST_W-1:0];

endmodule
`default_nettype wire

// ----- hw/rtl/psrch_checker.sv -----
// Port-level checker for the shift search block and its bind to the top level.
`default_nettype none
module psrch_checker import psrch_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input psrch_in_t  in_data,
  input logic       out_valid,
  input logic       out_ready,
  input psrch_out_t out_data
);

  // Reset leaves no result pending.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A pending result holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // No new word is taken while a result waits.
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // Only a last word can start a search, so other words give no result next cycle.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_data.last |=> !out_valid)
    else $error("result without a last word");

  // The reported shift stays within the largest possible search range.
  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.best_shift >= -SHIFT_W'(MAX_LENGTH / 4) &&
                  out_data.best_shift <= SHIFT_W'(MAX_LENGTH / 4))
    else $error("best shift outside search range");

endmodule

bind projection_shift_search psrch_checker u_psrch_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// ----- verif/tb.sv -----
// Testbench for the shift search block: a directed table, then random jobs checked by a predictor.
`timescale 1ns / 1ps
module tb;
  import psrch_pkg::*;

  localparam int     TOTAL_WORDS = 1950;
  localparam int     CALM_WORDS  = 150;
  localparam int     FULL_JOB    = MAX_LENGTH + 6;
  localparam int     LONG_HOLD   = 3000;
  localparam int     QUIET_LIMIT = 1500000;
  localparam longint COST_CAP    = longint'(COST_MAX);

  typedef struct {
    psrch_in_t  w;
    bit         typed;
    psrch_out_t res;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  psrch_in_t  in_data;
  logic       out_valid;
  logic       out_ready;
  psrch_out_t out_data;

  psrch_point_t ref_pts[MAX_LENGTH];
  psrch_point_t cmp_pts[MAX_LENGTH];
  int           ref_len = 0;
  int           cmp_len = 0;
  psrch_out_t   pending_best[$];
  row_t         plan[$];

  int errors        = 0;
  int words_sent    = 0;
  int quiet         = 0;
  int send_idle_pct = 10;
  int recv_idle_pct = 8;
  bit calm          = 1'b0;
  bit hold_request  = 1'b0;

  projection_shift_search uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint cross_mag(psrch_point_t a, psrch_point_t b);
    longint d;
    d = longint'($signed(a.x)) * longint'($signed(b.y))
      - longint'($signed(b.x)) * longint'($signed(a.y));
    return (d < 0) ? -d : d;
  endfunction

  // Exhaustive search over the loaded points; a later shift wins only if strictly cheaper.
  function automatic psrch_out_t best_alignment();
    int         span;
    int         best;
    int         j;
    longint     sum;
    longint     least;
    longint     t;
    psrch_out_t res;
    span  = (ref_len / 4 > cmp_len / 4) ? ref_len / 4 : cmp_len / 4;
    least = 0;
    best  = 0;
    for (int s = -span; s <= span; s++) begin
      sum = 0;
      for (int i = 0; i < ref_len; i++) begin
        j = i + s;
        if (j >= 0 && j < cmp_len) begin
          t   = cross_mag(ref_pts[i], cmp_pts[j]);
          sum = (t > COST_CAP - sum) ? COST_CAP : sum + t;
        end
      end
      if (s == -span || sum < least) begin
        least = sum;
        best  = s;
      end
    end
    res.best_shift = SHIFT_W'(best);
    res.best_cost  = COST_W'(least);
    return res;
  endfunction

  function automatic void add_row(int fx, int fy, bit fv, int sx, int sy, bit sv, bit fin,
                                  bit typed, int shift, longint cost);
    row_t r;
    r.w.first_x      = SAMPLE_W'(fx);
    r.w.first_y      = SAMPLE_W'(fy);
    r.w.first_valid  = fv;
    r.w.second_x     = SAMPLE_W'(sx);
    r.w.second_y     = SAMPLE_W'(sy);
    r.w.second_valid = sv;
    r.w.last         = fin;
    r.typed          = typed;
    r.res.best_shift = SHIFT_W'(shift);
    r.res.best_cost  = COST_W'(cost);
    plan.insert(plan.size(), r);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
      1:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
      2:       return SAMPLE_W'($urandom_range(0, 16) - 8);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0:       return 100;
      1:       return 75;
      default: return 30;
    endcase
  endfunction

  function automatic row_t random_word(int pf, int pc, bit fin);
    row_t r;
    r.w.first_x      = pick_sample();
    r.w.first_y      = pick_sample();
    r.w.first_valid  = ($urandom_range(1, 100) <= pf);
    r.w.second_x     = pick_sample();
    r.w.second_y     = pick_sample();
    r.w.second_valid = ($urandom_range(1, 100) <= pc);
    r.w.last         = fin;
    r.typed          = 1'b0;
    r.res            = '0;
    return r;
  endfunction

  task automatic report(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // Offers one word, waits for it to be taken, then updates the predicted stores.
  task automatic send_word(input row_t r);
    psrch_out_t found;
    if (!calm && $urandom_range(1, 100) <= send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r.w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (r.w.first_valid && ref_len < MAX_LENGTH) begin
      ref_pts[ref_len].x = r.w.first_x;
      ref_pts[ref_len].y = r.w.first_y;
      ref_len++;
    end
    if (r.w.second_valid && cmp_len < MAX_LENGTH) begin
      cmp_pts[cmp_len].x = r.w.second_x;
      cmp_pts[cmp_len].y = r.w.second_y;
      cmp_len++;
    end
    if (r.w.last) begin
      found   = best_alignment();
      ref_len = 0;
      cmp_len = 0;
      pending_best.insert(pending_best.size(), r.typed ? r.res : found);
    end
  endtask

  task automatic send_job(int count, int pf, int pc);
    for (int k = 0; k < count; k++) begin
      calm = (words_sent >= TOTAL_WORDS - CALM_WORDS);
      send_word(random_word(pf, pc, k == count - 1));
    end
  endtask

  initial begin
    bit full_done;
    bit hold_done;
    int len;
    int pick;
    full_done = 1'b0;
    hold_done = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;

    // Trivial jobs: empty vectors, one side only, and a single pair at the extremes.
    add_row(0, 0, 0, 0, 0, 0, 1, 1, 0, 0);
    add_row(-32768, 32767, 1, 0, 0, 0, 1, 1, 0, 0);
    add_row(0, 0, 0, 32767, -32768, 1, 1, 1, 0, 0);
    add_row(-32768, -32768, 1, 32767, -32768, 1, 1, 1, 0, 2147450880);
    // All-zero points tie at every shift, so the most negative shift is kept.
    for (int k = 0; k < 4; k++) add_row(0, 0, 1, 0, 0, 1, k == 3, k == 3, -1, 0);
    for (int k = 0; k < 8; k++)
      add_row(k * 4111 - 15000, 9000 - k * 2503, 1, 300 * k - 1000, k * k * 97 - 3000,
              k < 3, k == 7, 0, 0, 0);
    for (int k = 0; k < 5; k++)
      add_row(32767, (k % 2) ? 32767 : -32768, 1, (k % 2) ? -32768 : 32767, 32767, 1,
              k == 4, 0, 0, 0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    foreach (plan[k]) send_word(plan[k]);

    while (words_sent < TOTAL_WORDS) begin
      send_idle_pct = (pick_pct() == 100) ? 0 : $urandom_range(5, 40);
      recv_idle_pct = (pick_pct() == 100) ? 0 : $urandom_range(5, 30);
      if (!hold_done && words_sent >= 300) begin
        hold_done    = 1'b1;
        hold_request = 1'b1;
      end
      if (!full_done && words_sent >= 500) begin
        // Both stores overflow here, so the surplus words must be dropped.
        full_done = 1'b1;
        send_job(FULL_JOB, 100, 100);
      end else begin
        pick = $urandom_range(1, 100);
        len  = (pick <= 80) ? $urandom_range(1, 16) :
               (pick <= 95) ? $urandom_range(17, 60) : $urandom_range(61, 120);
        send_job(len, pick_pct(), pick_pct());
      end
    end
    in_valid <= 1'b0;

    while (pending_best.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_best.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result side: random ready bursts, one long hold-off, and the field checks.
  initial begin
    int         hold;
    psrch_out_t want;
    hold = 0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_best.size() == 0) begin
          report($sformatf("result word with none pending: shift %0d, cost %0d",
                           longint'($signed(out_data.best_shift)), out_data.best_cost));
        end else begin
          want = pending_best.pop_front();
          if (out_data.best_shift !== want.best_shift)
            report($sformatf("best_shift: expected %0d, got %0d",
                             longint'($signed(want.best_shift)),
                             longint'($signed(out_data.best_shift))));
          if (out_data.best_cost !== want.best_cost)
            report($sformatf("best_cost: expected %0d, got %0d",
                             want.best_cost, out_data.best_cost));
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold         = LONG_HOLD;
      end else if (!calm && hold == 0 && $urandom_range(1, 100) <= recv_idle_pct) begin
        hold = $urandom_range(1, 9);
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
